### hw/rtl/drdx_pkg.sv
// ----------------------------------------------------------------------------
// drdx_pkg
// Shared types and constants for the distinct random draw block.
// ----------------------------------------------------------------------------
package drdx_pkg;

  localparam int VAL_W          = 15;                 // value and sample width
  localparam int CNT_W          = 16;                 // draw count width
  localparam int CFG_W          = 16;                 // widest config register
  localparam int MAX_EXCLUSIONS = 256;
  localparam int EXCL_W         = $clog2(MAX_EXCLUSIONS + 1);
  localparam int RANDOM_TOP     = 32767;

  // Used-value bitmap, stored as rows of bits
  localparam int MAP_BITS  = 1 << VAL_W;
  localparam int MAP_ROW_W = 32;
  localparam int MAP_ROWS  = MAP_BITS / MAP_ROW_W;
  localparam int ROW_AW    = $clog2(MAP_ROWS);
  localparam int BIT_AW    = $clog2(MAP_ROW_W);
  localparam int DIV_STEPS = VAL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_SAMPLE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_ACCEPT  = 4'd0,
    ST_REJECT  = 4'd1,
    ST_LOADED  = 4'd2,
    ST_CLEARED = 4'd3,
    ST_LOWHIGH = 4'd4,
    ST_TOOMANY = 4'd5,
    ST_BORDER  = 4'd6,
    ST_REPEAT  = 4'd7,
    ST_DONE    = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    CFG_RANGE_LOW  = 2'd0,
    CFG_RANGE_HIGH = 2'd1,
    CFG_DRAW_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_WIN,
    S_DIV,
    S_RD,
    S_CHK
  } state_t;

  typedef enum logic [1:0] {
    PH_L0,
    PH_R0,
    PH_VAL
  } phase_t;

endpackage

### hw/rtl/distinct_random_draw_with_exclusions.sv
// ----------------------------------------------------------------------------
// distinct_random_draw_with_exclusions
// Draws distinct values in [range_low, range_high] from raw samples,
// skipping a loaded exclusion list; one result item per input item.
// ----------------------------------------------------------------------------
// Items are taken one at a time while busy is low, and each gives exactly one
// result, shown for a single cycle under out_valid; the receiver cannot stall
// it. Invalid modes, a full exclusion list and failed sample checks answer
// straight from idle. A load does a bitmap row read, then check and write
// back. A sample does a window check, a 15-step serial remainder by the
// range width, then the bitmap read-modify-write. The first sample to pass
// the checks after reset or any configuration write also recomputes the
// window bounds with the same remainder unit. After reset, and for each clear
// item, the bitmap is swept one 32-bit row per cycle over all 1024 rows
// with busy high; the clear item's result follows the sweep.
module distinct_random_draw_with_exclusions
  import drdx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_mode,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_drawn_value,
  output logic [3:0]       out_status,
  output logic             out_last_value,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Configuration
  logic [VAL_W-1:0] range_low_r, range_high_r;
  logic [CNT_W-1:0] draw_count_r;

  // Control state
  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [ROW_AW-1:0]   clr_row_r, clr_row_nxt;
  logic                clr_reply_r, clr_reply_nxt;
  logic [EXCL_W-1:0]   excl_total_r, excl_total_nxt;
  logic [CNT_W-1:0]    drawn_total_r, drawn_total_nxt;
  logic                repeat_err_r, repeat_err_nxt;
  logic                bounds_ok_r, bounds_ok_nxt;
  logic [STEP_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload
  logic                is_load_r, is_load_nxt;
  logic [VAL_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]    samp_r, samp_nxt;
  logic [VAL_W-1:0]    l0_r, l0_nxt;
  logic [VAL_W-1:0]    r0_r, r0_nxt;
  logic [VAL_W-1:0]    div_num_r, div_num_nxt;
  logic [CNT_W-1:0]    div_rem_r, div_rem_nxt;
  logic [VAL_W-1:0]    out_drawn_r, out_drawn_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  // Bitmap port
  logic                  ram_we;
  logic [ROW_AW-1:0]     ram_waddr;
  logic [MAP_ROW_W-1:0]  ram_wdata;
  logic [MAP_ROW_W-1:0]  ram_rdata;
  logic [MAP_ROW_W-1:0]  bit_mask;

  // Shared conditions
  logic             accept;
  mode_t            mode_in;
  logic [CNT_W-1:0] width_w;
  logic [CNT_W:0]   need_w;
  logic             pre_fail;
  status_t          pre_st;
  logic             excl_full;
  logic             win_out;
  logic             div_last;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W-1:0] rem_step;
  logic             map_hit;

  assign accept  = start && !busy;
  assign mode_in = mode_t'(in_mode);
  assign busy    = (state_r != S_IDLE);

  // Range width; meaningful only when low <= high
  assign width_w = {1'b0, range_high_r} - {1'b0, range_low_r} + CNT_W'(1);
  assign need_w  = {1'b0, draw_count_r} + (CNT_W + 1)'(excl_total_r);

  always_comb begin
    pre_fail = 1'b1;
    pre_st   = ST_REJECT;
    if (range_low_r > range_high_r) begin
      pre_st = ST_LOWHIGH;
    end else if (need_w > {1'b0, width_w}) begin
      pre_st = ST_TOOMANY;
    end else if ({1'b0, range_high_r} > CNT_W'(RANDOM_TOP)) begin
      pre_st = ST_BORDER;
    end else if (repeat_err_r) begin
      pre_st = ST_REPEAT;
    end else if (drawn_total_r >= draw_count_r) begin
      pre_st = ST_DONE;
    end else begin
      pre_fail = 1'b0;
    end
  end

  assign excl_full = (excl_total_r >= EXCL_W'(MAX_EXCLUSIONS));
  assign win_out   = (samp_r < l0_r) || (samp_r > r0_r);
  assign div_last  = (div_cnt_r == STEP_W'(DIV_STEPS - 1));

  // One restoring step of the remainder by the range width
  assign rem_sh   = {div_rem_r, div_num_r[VAL_W-1]};
  assign rem_step = (rem_sh >= {1'b0, width_w}) ? CNT_W'(rem_sh - {1'b0, width_w})
                                                : rem_sh[CNT_W-1:0];

  assign bit_mask = MAP_ROW_W'(1) << key_r[BIT_AW-1:0];
  assign map_hit  = |(ram_rdata & bit_mask);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_row_r == ROW_AW'(MAP_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (mode_in)
            MODE_CLEAR:  state_nxt = S_CLR;
            MODE_LOAD:   state_nxt = excl_full ? S_IDLE : S_RD;
            MODE_SAMPLE: begin
              if (pre_fail) begin
                state_nxt = S_IDLE;
              end else begin
                state_nxt = bounds_ok_r ? S_WIN : S_DIV;
              end
            end
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_WIN: state_nxt = win_out ? S_IDLE : S_DIV;
      S_DIV: begin
        if (div_last) begin
          case (phase_r)
            PH_L0:   state_nxt = S_DIV;
            PH_R0:   state_nxt = S_WIN;
            PH_VAL:  state_nxt = S_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:    state_nxt = S_CHK;
      S_CHK:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    phase_nxt       = phase_r;
    clr_row_nxt     = clr_row_r;
    clr_reply_nxt   = clr_reply_r;
    excl_total_nxt  = excl_total_r;
    drawn_total_nxt = drawn_total_r;
    repeat_err_nxt  = repeat_err_r;
    bounds_ok_nxt   = bounds_ok_r;
    div_cnt_nxt     = div_cnt_r;
    is_load_nxt     = is_load_r;
    key_nxt         = key_r;
    samp_nxt        = samp_r;
    l0_nxt          = l0_r;
    r0_nxt          = r0_r;
    div_num_nxt     = div_num_r;
    div_rem_nxt     = div_rem_r;
    out_valid_nxt   = 1'b0;
    out_drawn_nxt   = '0;
    out_status_nxt  = out_status_r;
    out_last_nxt    = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = key_r[VAL_W-1:BIT_AW];
    ram_wdata       = ram_rdata | bit_mask;

    if (cfg_we) begin
      bounds_ok_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_row_r;
        ram_wdata   = '0;
        clr_row_nxt = clr_row_r + ROW_AW'(1);
        if (clr_row_r == ROW_AW'(MAP_ROWS - 1)) begin
          out_valid_nxt  = clr_reply_r;
          out_status_nxt = ST_CLEARED;
          clr_reply_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          key_nxt  = in_value;
          samp_nxt = in_value;
          case (mode_in)
            MODE_CLEAR: begin
              clr_row_nxt     = '0;
              clr_reply_nxt   = 1'b1;
              excl_total_nxt  = '0;
              drawn_total_nxt = '0;
              repeat_err_nxt  = 1'b0;
            end
            MODE_LOAD: begin
              is_load_nxt = 1'b1;
              if (excl_full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_TOOMANY;
              end
            end
            MODE_SAMPLE: begin
              is_load_nxt = 1'b0;
              if (pre_fail) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pre_st;
              end else if (!bounds_ok_r) begin
                // Recompute l0 = low mod w first
                phase_nxt   = PH_L0;
                div_num_nxt = range_low_r;
                div_rem_nxt = '0;
                div_cnt_nxt = '0;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_REJECT;
            end
          endcase
        end
      end
      S_WIN: begin
        if (win_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_REJECT;
        end else begin
          phase_nxt   = PH_VAL;
          div_num_nxt = samp_r - l0_r;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
        end
      end
      S_DIV: begin
        div_num_nxt = {div_num_r[VAL_W-2:0], 1'b0};
        div_rem_nxt = rem_step;
        div_cnt_nxt = div_cnt_r + STEP_W'(1);
        if (div_last) begin
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          case (phase_r)
            PH_L0: begin
              l0_nxt      = rem_step[VAL_W-1:0];
              phase_nxt   = PH_R0;
              div_num_nxt = VAL_W'(RANDOM_TOP) - range_high_r;
            end
            PH_R0: begin
              // r0 = top - ((top - high) mod w)
              r0_nxt        = VAL_W'(RANDOM_TOP) - rem_step[VAL_W-1:0];
              bounds_ok_nxt = !cfg_we;
            end
            PH_VAL: begin
              key_nxt = rem_step[VAL_W-1:0] + range_low_r;
            end
            default: begin
              phase_nxt = PH_L0;
            end
          endcase
        end
      end
      S_RD: begin
        // Row read in flight
      end
      S_CHK: begin
        out_valid_nxt = 1'b1;
        if (is_load_r) begin
          if (map_hit) begin
            repeat_err_nxt = 1'b1;
            out_status_nxt = ST_REPEAT;
          end else begin
            ram_we         = 1'b1;
            excl_total_nxt = excl_total_r + EXCL_W'(1);
            out_status_nxt = ST_LOADED;
          end
        end else begin
          if (map_hit) begin
            out_status_nxt = ST_REJECT;
          end else begin
            ram_we          = 1'b1;
            drawn_total_nxt = drawn_total_r + CNT_W'(1);
            out_status_nxt  = ST_ACCEPT;
            out_drawn_nxt   = key_r;
            out_last_nxt    = ((drawn_total_r + CNT_W'(1)) == draw_count_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= VAL_W'(1);
      range_high_r  <= VAL_W'(51);
      draw_count_r  <= CNT_W'(51);
      state_r       <= S_CLR;
      phase_r       <= PH_L0;
      clr_row_r     <= '0;
      clr_reply_r   <= 1'b0;
      excl_total_r  <= '0;
      drawn_total_r <= '0;
      repeat_err_r  <= 1'b0;
      bounds_ok_r   <= 1'b0;
      div_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RANGE_LOW:  range_low_r  <= cfg_data[VAL_W-1:0];
          CFG_RANGE_HIGH: range_high_r <= cfg_data[VAL_W-1:0];
          CFG_DRAW_COUNT: draw_count_r <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      clr_row_r     <= clr_row_nxt;
      clr_reply_r   <= clr_reply_nxt;
      excl_total_r  <= excl_total_nxt;
      drawn_total_r <= drawn_total_nxt;
      repeat_err_r  <= repeat_err_nxt;
      bounds_ok_r   <= bounds_ok_nxt;
      div_cnt_r     <= div_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_load_r    <= is_load_nxt;
    key_r        <= key_nxt;
    samp_r       <= samp_nxt;
    l0_r         <= l0_nxt;
    r0_r         <= r0_nxt;
    div_num_r    <= div_num_nxt;
    div_rem_r    <= div_rem_nxt;
    out_drawn_r  <= out_drawn_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  drdx_ram #(
    .WIDTH (MAP_ROW_W),
    .DEPTH (MAP_ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (key_r[VAL_W-1:BIT_AW]),
    .rd_data (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_drawn_r;
  assign out_status      = out_status_r;
  assign out_last_value  = out_last_r;

endmodule

### hw/rtl/drdx_ram.sv
// ----------------------------------------------------------------------------
// drdx_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module drdx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/drdx_checker.sv
// ----------------------------------------------------------------------------
// drdx_checker
// Port-level checks for the distinct random draw block, bound to the top.
// ----------------------------------------------------------------------------
module drdx_checker
  import drdx_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [1:0]       in_mode,
  input logic             out_valid,
  input logic [VAL_W-1:0] out_drawn_value,
  input logic [3:0]       out_status,
  input logic             out_last_value
);

  // A clear item starts the bitmap sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == MODE_CLEAR) |=> busy)
    else $error("clear item did not start sweep");

  // Only an accepted draw carries a value or the last flag
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ACCEPT) |-> (out_drawn_value == '0) && !out_last_value)
    else $error("payload set on non-accept result");

  // A clear result comes only at the end of a sweep
  a_clear_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_CLEARED) |-> $past(busy))
    else $error("clear result without sweep");

  // An accepted draw always went through the bitmap
  a_accept_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACCEPT) |-> $past(busy))
    else $error("draw accepted without bitmap access");

endmodule

bind distinct_random_draw_with_exclusions drdx_checker u_drdx_checker (.*);

### dv/distinct_random_draw_with_exclusions_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_random_draw_with_exclusions_test
// Sends clear, exclusion and sample items to the draw block under several
// window settings. A local copy of the used-value bitmap, the counters and
// the sticky repeat flag predicts each result, and every result is checked.
// ----------------------------------------------------------------------------
module distinct_random_draw_with_exclusions_test;
  import drdx_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    logic [VAL_W-1:0] value;
    status_t          status;
    logic             last;
  } draw_result_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  logic [1:0]       in_mode   = MODE_CLEAR;
  logic [VAL_W-1:0] in_value  = '0;
  logic             out_valid;
  logic [VAL_W-1:0] out_drawn_value;
  logic [3:0]       out_status;
  logic             out_last_value;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = CFG_RANGE_LOW;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Predicted block state
  bit          taken_map [MAP_BITS];
  int unsigned low_reg, high_reg, count_reg;
  int unsigned exclusions_loaded, draws_made;
  bit          repeat_seen;

  draw_result_t expected_draws [$];
  draw_result_t head;
  int           items_sent, results_seen, mismatches, settings_used, last_tally;
  int           status_tally [9];
  bit           gaps_on = 1'b1;

  distinct_random_draw_with_exclusions DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_drawn_value (out_drawn_value),
    .out_status      (out_status),
    .out_last_value  (out_last_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_draw_state();
    foreach (taken_map[i]) taken_map[i] = 1'b0;
    exclusions_loaded = 0;
    draws_made        = 0;
    repeat_seen       = 1'b0;
  endfunction

  function automatic status_t sample_outcome(input int unsigned t, output int unsigned v);
    int unsigned w, l0, r0;
    v = 0;
    if (low_reg > high_reg) return ST_LOWHIGH;
    w = high_reg - low_reg + 1;
    if (count_reg + exclusions_loaded > w) return ST_TOOMANY;
    if (high_reg > RANDOM_TOP) return ST_BORDER;
    if (repeat_seen) return ST_REPEAT;
    if (draws_made >= count_reg) return ST_DONE;
    // unbiased window: only whole multiples of the range width are kept
    l0 = low_reg % w;
    r0 = high_reg + ((RANDOM_TOP - high_reg) / w) * w;
    if (t < l0 || t > r0) return ST_REJECT;
    v = ((t - l0) % w + low_reg) & (MAP_BITS - 1);
    if (taken_map[v]) return ST_REJECT;
    taken_map[v] = 1'b1;
    draws_made = (draws_made + 1) & 32'hFFFF;
    return ST_ACCEPT;
  endfunction

  function automatic draw_result_t predict_draw(input mode_t m, input logic [VAL_W-1:0] val);
    draw_result_t r;
    int unsigned  v;
    r.value = '0;
    r.last  = 1'b0;
    case (m)
      MODE_CLEAR: begin
        clear_draw_state();
        r.status = ST_CLEARED;
      end
      MODE_LOAD: begin
        if (exclusions_loaded >= MAX_EXCLUSIONS) begin
          r.status = ST_TOOMANY;
        end else if (taken_map[val]) begin
          repeat_seen = 1'b1;
          r.status    = ST_REPEAT;
        end else begin
          taken_map[val] = 1'b1;
          exclusions_loaded++;
          r.status = ST_LOADED;
        end
      end
      MODE_SAMPLE: begin
        r.status = sample_outcome(32'(val), v);
        if (r.status == ST_ACCEPT) begin
          r.value = v[VAL_W-1:0];
          r.last  = (draws_made == count_reg);
        end
      end
      default: r.status = ST_REJECT;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Hold start high until the block takes the item, then log its expectation
  task automatic send_item(input mode_t m, input logic [VAL_W-1:0] val);
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_mode  <= m;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_draws.push_back(predict_draw(m, val));
    if (m != MODE_NONE) items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_RANGE_LOW:  low_reg = 32'(data[VAL_W-1:0]);
      CFG_RANGE_HIGH: high_reg = 32'(data[VAL_W-1:0]);
      default:        count_reg = 32'(data);
    endcase
  endtask

  task automatic set_draw_window(input logic [CFG_W-1:0] lo, hi, cnt);
    drain_results();
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
    write_reg(CFG_DRAW_COUNT, cnt);
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_status < 9) status_tally[out_status]++;
      if (out_last_value) last_tally++;
      if (expected_draws.size() == 0) begin
        flag_mismatch($sformatf("result with no item pending: status %0d value %0d",
                                out_status, out_drawn_value));
      end else begin
        head = expected_draws.pop_front();
        if (out_status !== head.status)
          flag_mismatch($sformatf("status %0d, expected %s", out_status, head.status.name()));
        if (out_drawn_value !== head.value)
          flag_mismatch($sformatf("drawn value %0d, expected %0d", out_drawn_value, head.value));
        if (out_last_value !== head.last)
          flag_mismatch($sformatf("last flag %b, expected %b", out_last_value, head.last));
      end
    end
  end

  // Reset window 1..51: samples below and above the unbiased window, a
  // repeated draw and the unused mode
  task automatic test_window_edges();
    send_item(MODE_SAMPLE, 15'd0);
    send_item(MODE_SAMPLE, 15'd32767);
    send_item(MODE_SAMPLE, 15'd1);
    send_item(MODE_SAMPLE, 15'd1);
    send_item(MODE_NONE, 15'h5555);
  endtask

  task automatic test_sample_checks();
    send_item(MODE_LOAD, 15'd0);     // outside the window, still counted
    send_item(MODE_SAMPLE, 15'd20);  // count plus exclusions exceeds width
    send_item(MODE_LOAD, 15'd1);     // already drawn: sticky repeat
    send_item(MODE_SAMPLE, 15'd20);
    send_item(MODE_CLEAR, 15'd0);
    set_draw_window(16'd1, 16'd51, 16'd0);
    send_item(MODE_SAMPLE, 15'd7);
    send_item(MODE_LOAD, 15'd5);
    send_item(MODE_LOAD, 15'd5);
    send_item(MODE_SAMPLE, 15'd7);
    send_item(MODE_CLEAR, 15'h7FFF);
    set_draw_window(16'd10, 16'd5, 16'd51);
    send_item(MODE_SAMPLE, 15'd7);
  endtask

  task automatic test_full_span();
    set_draw_window(16'd0, 16'd32767, 16'h8000);
    send_item(MODE_CLEAR, 15'd0);
    send_item(MODE_SAMPLE, 15'd0);
    send_item(MODE_SAMPLE, 15'd32767);
    send_item(MODE_SAMPLE, 15'd16384);
    // top bit of the range words is dropped: single-value window at 32767
    set_draw_window(16'hFFFF, 16'hFFFF, 16'd1);
    send_item(MODE_CLEAR, 15'd0);
    send_item(MODE_SAMPLE, 15'd0);
    send_item(MODE_SAMPLE, 15'd12345);
  endtask

  task automatic test_exclusion_limit();
    int unsigned v;
    int          i;
    set_draw_window(16'd0, 16'd32767, 16'd4);
    send_item(MODE_CLEAR, 15'd0);
    for (i = 0; i < MAX_EXCLUSIONS; i++) begin
      do v = $urandom_range(0, RANDOM_TOP); while (taken_map[v]);
      send_item(MODE_LOAD, VAL_W'(v));
    end
    send_item(MODE_LOAD, VAL_W'(v));  // a repeat, but the full list answers first
    send_item(MODE_LOAD, VAL_W'($urandom_range(0, RANDOM_TOP)));
    while (draws_made < count_reg)
      send_item(MODE_SAMPLE, VAL_W'($urandom_range(0, RANDOM_TOP)));
    send_item(MODE_SAMPLE, VAL_W'($urandom_range(0, RANDOM_TOP)));
    drain_results();
  endtask

  task automatic test_random_draws();
    int unsigned      lo, hi, cnt, w, l0, r0, t, n_excl, budget, extra, pick, tries;
    int               phase, n, i;
    bit               window_ok, can_draw;
    logic [CFG_W-1:0] lo_word, hi_word;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = !(phase >= 6 && phase < 12);
      pick    = $urandom_range(0, 9);
      n_excl  = $urandom_range(0, 6);
      lo      = $urandom_range(0, RANDOM_TOP);
      if (pick < 6 || pick == 8) begin
        w = $urandom_range(1, (pick == 8) ? 200 : 40);
        if (lo > RANDOM_TOP - w + 1) lo = RANDOM_TOP - w + 1;
        hi = lo + w - 1;
        if (pick == 8) begin
          case ($urandom_range(0, 2))
            0:       cnt = 16'hFFFF;
            1:       cnt = w + $urandom_range(1, 8);
            default: cnt = (n_excl <= w) ? w - n_excl + 1 : w;
          endcase
        end else begin
          cnt = ($urandom_range(0, 2) == 0 && n_excl <= w) ? w - n_excl : $urandom_range(0, w);
        end
      end else if (pick == 6) begin
        w = $urandom_range(41, 3000);
        if (lo > RANDOM_TOP - w + 1) lo = RANDOM_TOP - w + 1;
        hi  = lo + w - 1;
        cnt = $urandom_range(1, 40);
      end else if (pick == 7) begin
        lo  = $urandom_range(1, RANDOM_TOP);
        hi  = $urandom_range(0, lo - 1);
        cnt = $urandom_range(0, 50);
      end else begin
        lo  = 0;
        hi  = RANDOM_TOP;
        cnt = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(1, 60);
      end
      lo_word = CFG_W'(lo);
      hi_word = CFG_W'(hi);
      lo_word[CFG_W-1] = $urandom_range(0, 1);
      hi_word[CFG_W-1] = $urandom_range(0, 1);
      set_draw_window(lo_word, hi_word, CFG_W'(cnt));
      if ($urandom_range(0, 99) < 85)
        send_item(MODE_CLEAR, VAL_W'($urandom_range(0, RANDOM_TOP)));

      for (i = 0; i < n_excl; i++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0 || lo > hi) begin
          t = $urandom_range(0, RANDOM_TOP);
        end else if (pick == 1 && i > 0) begin
          // t still holds the previous exclusion
        end else begin
          tries = 0;
          do begin
            t = $urandom_range(lo, hi);
            tries++;
          end while (taken_map[t] && tries < 4);
        end
        send_item(MODE_LOAD, VAL_W'(t));
      end

      window_ok = (lo <= hi);
      w  = window_ok ? hi - lo + 1 : 1;
      l0 = lo % w;
      r0 = hi + ((RANDOM_TOP - hi) / w) * w;
      can_draw = window_ok && count_reg + exclusions_loaded <= w && !repeat_seen;
      budget   = !can_draw ? 8 : (4 * w + 12 > 160) ? 160 : 4 * w + 12;
      extra    = $urandom_range(1, 3);
      for (n = 0; n < budget && items_sent < ITEM_TARGET; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_item(MODE_NONE, VAL_W'($urandom_range(0, RANDOM_TOP)));
        end else if (pick < 7) begin
          send_item(MODE_LOAD, VAL_W'($urandom_range(0, RANDOM_TOP)));
        end else if (pick < 8) begin
          send_item(MODE_CLEAR, VAL_W'($urandom_range(0, RANDOM_TOP)));
        end else begin
          pick = $urandom_range(0, 99);
          if (!window_ok || pick >= 85) t = $urandom_range(0, RANDOM_TOP);
          else if (pick < 70) t = $urandom_range(l0, r0);
          else if (pick < 78 && l0 > 0) t = $urandom_range(0, l0 - 1);
          else if (r0 < RANDOM_TOP) t = $urandom_range(r0 + 1, RANDOM_TOP);
          else t = $urandom_range(l0, r0);
          send_item(MODE_SAMPLE, VAL_W'(t));
          if (draws_made >= count_reg) begin
            if (extra == 0) break;
            extra--;
          end
        end
      end
      phase++;
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  initial begin
    low_reg   = 1;
    high_reg  = 51;
    count_reg = 51;
    clear_draw_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_window_edges();
    test_sample_checks();
    test_full_span();
    test_exclusion_limit();
    test_random_draws();

    drain_results();
    repeat (32) @(posedge clk);
    if (expected_draws.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_draws.size()));

    $display("Covered %0d items under %0d window settings, %0d results checked.",
             items_sent, settings_used, results_seen);
    $display("Seen: %0d drawn (%0d last), %0d rejected, %0d loaded, %0d cleared,",
             status_tally[ST_ACCEPT], last_tally, status_tally[ST_REJECT],
             status_tally[ST_LOADED], status_tally[ST_CLEARED]);
    $display("      %0d low>high, %0d too many, %0d repeat, %0d done.",
             status_tally[ST_LOWHIGH], status_tally[ST_TOOMANY],
             status_tally[ST_REPEAT], status_tally[ST_DONE]);
    if (mismatches == 0) begin
      $display("distinct_random_draw_with_exclusions: match");
    end else begin
      $display("distinct_random_draw_with_exclusions: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ERROR: run did not finish in time");
    $display("distinct_random_draw_with_exclusions: mismatch");
    $finish;
  end

endmodule
